@@ hdl/pps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, register indexes and face codes of the parallelepiped
// surface point sampler.
// ----------------------------------------------------------------------------
package pps_pkg;

   localparam int COORD_FRAC_BITS_DEF = 16;
   localparam int DRAW_BITS_DEF       = 16;

   localparam int HALF_W      = 32;           // half lengths and tangents
   localparam int AREA_W      = 48;           // face areas
   localparam int CUM_W       = AREA_W + 3;   // cumulative area, six terms
   localparam int COORD_W     = 32;           // output coordinates
   localparam int FACE_W      = 3;
   localparam int PROD_W      = 64;           // 32x32 product
   localparam int MUL_SPLIT   = 32;           // low slice of a split multiply
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   // cycles for the derived terms to settle after a write
   localparam int DERIVE_CYCLES = 3;
   localparam int DERIVE_CNT_W  = 2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_X    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_Y    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_HALF_Z    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TAN_ALPHA = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_TAN_TCP   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_TAN_TSP   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_AREA_X    = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_AREA_Y    = 3'd7;

   // face codes
   localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
   localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
   localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd2;
   localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd3;
   localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd4;
   localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd5;

endpackage

@@ hdl/pps_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pps_cfg
// Register file plus a three stage pipeline that turns the raw registers
// into cumulative areas, face corners and edge magnitudes.
// ----------------------------------------------------------------------------
module pps_cfg
   import pps_pkg::*;
#(
   parameter int  COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   localparam int AW = PROD_W - COORD_FRAC_BITS,
   localparam int EW = AW + 1,
   localparam int PW = AW + 2
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output logic                   busy,
   output logic [CUM_W-1:0]       cum0,
   output logic [CUM_W-1:0]       cum1,
   output logic [CUM_W-1:0]       cum2,
   output logic [CUM_W-1:0]       cum3,
   output logic [CUM_W-1:0]       cum4,
   output logic [CUM_W-1:0]       cum5,
   output logic signed [PW-1:0]   px_base,
   output logic signed [PW-1:0]   px_f1,
   output logic signed [PW-1:0]   px_f3,
   output logic signed [PW-1:0]   px_f5,
   output logic signed [PW-1:0]   py_base,
   output logic signed [PW-1:0]   py_f3,
   output logic signed [PW-1:0]   py_f5,
   output logic signed [PW-1:0]   pz_neg,
   output logic signed [PW-1:0]   pz_pos,
   output logic [EW-1:0]          mag_ex,
   output logic [EW-1:0]          mag_ay,
   output logic [EW-1:0]          mag_cz,
   output logic [EW-1:0]          mag_ax,
   output logic [EW-1:0]          mag_cx,
   output logic [EW-1:0]          mag_cy,
   output logic                   neg_ax,
   output logic                   neg_cx,
   output logic                   neg_cy
);

   // raw registers
   logic [HALF_W-1:0]        half_x_ff, half_y_ff, half_z_ff;
   logic signed [HALF_W-1:0] tan_a_ff, tan_c_ff, tan_s_ff;
   logic [AREA_W-1:0]        area_x_ff, area_y_ff;
   logic [DERIVE_CNT_W-1:0]  cnt_ff;

   // derive stage 1
   logic [PROD_W-1:0]        pxy_in, pxy_ff;
   logic signed [PROD_W:0]   prod_a_in, prod_a_ff;
   logic signed [PROD_W:0]   prod_c_in, prod_c_ff;
   logic signed [PROD_W:0]   prod_s_in, prod_s_ff;
   logic [CUM_W-1:0]         cum1_in, cum1_ff, cum2_in, cum2_ff, cum3_in, cum3_ff;

   // derive stage 2
   logic [PROD_W-1:0]        az_wide;
   logic [AREA_W-1:0]        az_sat;
   logic [CUM_W-1:0]         cum4_in, cum4_ff, cum5_in, cum5_ff;
   logic signed [AW-1:0]     a_ff, c_ff, s_ff;

   // derive stage 3
   logic signed [PW-1:0]     xe, ye, ze, ae, ce, se;
   logic signed [PW-1:0]     px_base_ff, px_f1_ff, px_f3_ff, px_f5_ff;
   logic signed [PW-1:0]     py_base_ff, py_f3_ff, py_f5_ff, pz_neg_ff, pz_pos_ff;
   logic signed [EW-1:0]     two_a, two_c, two_s;
   logic [EW-1:0]            mag_ax_ff, mag_cx_ff, mag_cy_ff;
   logic                     neg_ax_ff, neg_cx_ff, neg_cy_ff;

   assign csr_ready = 1'b1;
   assign busy      = (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         half_x_ff <= '0;
         half_y_ff <= '0;
         half_z_ff <= '0;
         tan_a_ff  <= '0;
         tan_c_ff  <= '0;
         tan_s_ff  <= '0;
         area_x_ff <= '0;
         area_y_ff <= '0;
         cnt_ff    <= DERIVE_CNT_W'(DERIVE_CYCLES);
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_HALF_X:    half_x_ff <= csr_wdata[HALF_W-1:0];
               REG_HALF_Y:    half_y_ff <= csr_wdata[HALF_W-1:0];
               REG_HALF_Z:    half_z_ff <= csr_wdata[HALF_W-1:0];
               REG_TAN_ALPHA: tan_a_ff  <= csr_wdata[HALF_W-1:0];
               REG_TAN_TCP:   tan_c_ff  <= csr_wdata[HALF_W-1:0];
               REG_TAN_TSP:   tan_s_ff  <= csr_wdata[HALF_W-1:0];
               REG_AREA_X:    area_x_ff <= csr_wdata[AREA_W-1:0];
               REG_AREA_Y:    area_y_ff <= csr_wdata[AREA_W-1:0];
               default: begin
               end
            endcase
            cnt_ff <= DERIVE_CNT_W'(DERIVE_CYCLES);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // stage 1: products and the first cumulative sums
   always_comb begin
      pxy_in    = half_x_ff * half_y_ff;
      prod_a_in = $signed({1'b0, half_y_ff}) * tan_a_ff;
      prod_c_in = $signed({1'b0, half_z_ff}) * tan_c_ff;
      prod_s_in = $signed({1'b0, half_z_ff}) * tan_s_ff;
      cum1_in   = CUM_W'(area_x_ff) << 1;
      cum2_in   = cum1_in + CUM_W'(area_y_ff);
      cum3_in   = (CUM_W'(area_x_ff) + CUM_W'(area_y_ff)) << 1;
   end

   // stage 2: z area (4*Dx*Dy, saturated), floored shear terms
   always_comb begin
      az_wide = pxy_ff >> (COORD_FRAC_BITS - 2);
      az_sat  = (|az_wide[PROD_W-1:AREA_W]) ? {AREA_W{1'b1}} : az_wide[AREA_W-1:0];
      cum4_in = cum3_ff + CUM_W'(az_sat);
      cum5_in = cum3_ff + (CUM_W'(az_sat) << 1);
   end

   // stage 3: corners and edge magnitudes
   always_comb begin
      xe    = PW'(half_x_ff);
      ye    = PW'(half_y_ff);
      ze    = PW'(half_z_ff);
      ae    = PW'(a_ff);
      ce    = PW'(c_ff);
      se    = PW'(s_ff);
      two_a = {a_ff, 1'b0};
      two_c = {c_ff, 1'b0};
      two_s = {s_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      pxy_ff     <= pxy_in;
      prod_a_ff  <= prod_a_in;
      prod_c_ff  <= prod_c_in;
      prod_s_ff  <= prod_s_in;
      cum1_ff    <= cum1_in;
      cum2_ff    <= cum2_in;
      cum3_ff    <= cum3_in;

      cum4_ff    <= cum4_in;
      cum5_ff    <= cum5_in;
      a_ff       <= prod_a_ff[PROD_W-1:COORD_FRAC_BITS];
      c_ff       <= prod_c_ff[PROD_W-1:COORD_FRAC_BITS];
      s_ff       <= prod_s_ff[PROD_W-1:COORD_FRAC_BITS];

      px_base_ff <= -ce - ae - xe;
      px_f1_ff   <= -ce - ae + xe;
      px_f3_ff   <= -ce + ae - xe;
      px_f5_ff   <=  ce - ae - xe;
      py_base_ff <= -se - ye;
      py_f3_ff   <= -se + ye;
      py_f5_ff   <=  se - ye;
      pz_neg_ff  <= -ze;
      pz_pos_ff  <=  ze;
      neg_ax_ff  <= two_a[EW-1];
      neg_cx_ff  <= two_c[EW-1];
      neg_cy_ff  <= two_s[EW-1];
      mag_ax_ff  <= two_a[EW-1] ? (~two_a + 1'b1) : two_a;
      mag_cx_ff  <= two_c[EW-1] ? (~two_c + 1'b1) : two_c;
      mag_cy_ff  <= two_s[EW-1] ? (~two_s + 1'b1) : two_s;
   end

   assign cum0    = CUM_W'(area_x_ff);
   assign cum1    = cum1_ff;
   assign cum2    = cum2_ff;
   assign cum3    = cum3_ff;
   assign cum4    = cum4_ff;
   assign cum5    = cum5_ff;
   assign px_base = px_base_ff;
   assign px_f1   = px_f1_ff;
   assign px_f3   = px_f3_ff;
   assign px_f5   = px_f5_ff;
   assign py_base = py_base_ff;
   assign py_f3   = py_f3_ff;
   assign py_f5   = py_f5_ff;
   assign pz_neg  = pz_neg_ff;
   assign pz_pos  = pz_pos_ff;
   assign mag_ex  = EW'({half_x_ff, 1'b0});
   assign mag_ay  = EW'({half_y_ff, 1'b0});
   assign mag_cz  = EW'({half_z_ff, 1'b0});
   assign mag_ax  = mag_ax_ff;
   assign mag_cx  = mag_cx_ff;
   assign mag_cy  = mag_cy_ff;
   assign neg_ax  = neg_ax_ff;
   assign neg_cx  = neg_cx_ff;
   assign neg_cy  = neg_cy_ff;

endmodule

@@ hdl/parallelepiped_surface_point_sampler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// parallelepiped_surface_point_sampler_unit
// A request taken at a clock edge passes the eight stage datapath and gives
// its result on the rsp_ ports as one rsp_valid strobe.
// Throughput: one request per cycle while busy is low.
// Reset: clears the register file and valid bits to zero; busy stays high
// after reset and after each register write while the derived terms settle.
// Results cannot be held off by the receiver; the pipeline never stalls.
// ----------------------------------------------------------------------------
module parallelepiped_surface_point_sampler_unit
   import pps_pkg::*;
#(
   parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF,
   parameter int DRAW_BITS       = DRAW_BITS_DEF
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [DRAW_BITS-1:0]      req_face_draw,
   input  logic [DRAW_BITS-1:0]      req_u_draw,
   input  logic [DRAW_BITS-1:0]      req_v_draw,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata,
   output logic                      rsp_valid,
   output logic [FACE_W-1:0]         rsp_face_index,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [COORD_W-1:0] rsp_point_z,
   output logic                      rsp_saturated
);

   // AW: floored shear term, EW: edge (2x) magnitude, PW: corner,
   // SW: corner plus two scaled edges
   localparam int AW       = PROD_W - COORD_FRAC_BITS;
   localparam int EW       = AW + 1;
   localparam int PW       = AW + 2;
   localparam int SW       = AW + 4;
   localparam int HW       = EW - MUL_SPLIT;
   localparam int CHW      = CUM_W - MUL_SPLIT;
   localparam int STAGES   = 8;
   localparam int NCOORD   = 3;

   // edge vector codes: ex = 2X on x, ea = (2A, 2Y, 0), ec = (2C, 2S, 2Z)
   localparam logic [1:0] EDGE_X = 2'd0;
   localparam logic [1:0] EDGE_A = 2'd1;
   localparam logic [1:0] EDGE_C = 2'd2;

   // derived configuration terms
   logic [CUM_W-1:0]     cum0, cum1, cum2, cum3, cum4, cum5;
   logic signed [PW-1:0] px_base, px_f1, px_f3, px_f5;
   logic signed [PW-1:0] py_base, py_f3, py_f5, pz_neg, pz_pos;
   logic [EW-1:0]        mag_ex, mag_ay, mag_cz, mag_ax, mag_cx, mag_cy;
   logic                 neg_ax, neg_cx, neg_cy;

   logic                 accept;
   logic [STAGES-1:0]    vld_ff;

   // stage 1: request capture
   logic [DRAW_BITS-1:0] fd1_ff, ud1_ff, vd1_ff;

   // stage 2: selector partial products
   logic [MUL_SPLIT+DRAW_BITS-1:0] sp_lo2_ff;
   logic [CHW+DRAW_BITS-1:0]       sp_hi2_ff;
   logic [DRAW_BITS-1:0]           ud2_ff, vd2_ff;

   // stage 3: face choice
   logic [CUM_W:0]       sel3;
   logic [FACE_W-1:0]    face3_in, face3_ff;
   logic [DRAW_BITS-1:0] ud3_ff, vd3_ff;

   // stage 4: corner and edge selection, per coordinate lanes
   logic [1:0]           e1_code, e2_code;
   logic [EW:0]          ex_v [NCOORD];
   logic [EW:0]          ea_v [NCOORD];
   logic [EW:0]          ec_v [NCOORD];
   logic signed [PW-1:0] p4_in [NCOORD];
   logic signed [PW-1:0] p4_ff [NCOORD];
   logic [EW:0]          e14_in [NCOORD];
   logic [EW:0]          e24_in [NCOORD];
   logic [EW:0]          e14_ff [NCOORD];
   logic [EW:0]          e24_ff [NCOORD];
   logic [FACE_W-1:0]    face4_ff;
   logic [DRAW_BITS-1:0] ud4_ff, vd4_ff;

   // stage 5: split edge products
   logic [MUL_SPLIT+DRAW_BITS-1:0] q1lo5_ff [NCOORD];
   logic [MUL_SPLIT+DRAW_BITS-1:0] q2lo5_ff [NCOORD];
   logic [HW+DRAW_BITS-1:0]        q1hi5_ff [NCOORD];
   logic [HW+DRAW_BITS-1:0]        q2hi5_ff [NCOORD];
   logic                           n15_ff [NCOORD];
   logic                           n25_ff [NCOORD];
   logic signed [PW-1:0]           p5_ff [NCOORD];
   logic [FACE_W-1:0]              face5_ff;

   // stage 6: scaled edge magnitudes
   logic [EW:0]          r16_wide [NCOORD];
   logic [EW:0]          r26_wide [NCOORD];
   logic [EW-1:0]        r16_ff [NCOORD];
   logic [EW-1:0]        r26_ff [NCOORD];
   logic                 n16_ff [NCOORD];
   logic                 n26_ff [NCOORD];
   logic signed [PW-1:0] p6_ff [NCOORD];
   logic [FACE_W-1:0]    face6_ff;

   // stage 7: signed sum
   logic signed [SW-1:0] sr1 [NCOORD];
   logic signed [SW-1:0] sr2 [NCOORD];
   logic signed [SW-1:0] sum7_in [NCOORD];
   logic signed [SW-1:0] sum7_ff [NCOORD];
   logic [FACE_W-1:0]    face7_ff;

   // stage 8: clip into the result registers
   logic [COORD_W-1:0]   pt_in [NCOORD];
   logic                 fits [NCOORD];
   logic [FACE_W-1:0]    rsp_face_ff;
   logic [COORD_W-1:0]   rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                 rsp_sat_ff;

   function automatic logic [EW:0] edge_pick(input logic [1:0] code,
                                             input logic [EW:0] ex_c,
                                             input logic [EW:0] ea_c,
                                             input logic [EW:0] ec_c);
      logic [EW:0] res;
      case (code)
         EDGE_X:  res = ex_c;
         EDGE_A:  res = ea_c;
         default: res = ec_c;
      endcase
      return res;
   endfunction

   // register file and derived terms
   pps_cfg #(
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .busy      (busy),
      .cum0      (cum0),
      .cum1      (cum1),
      .cum2      (cum2),
      .cum3      (cum3),
      .cum4      (cum4),
      .cum5      (cum5),
      .px_base   (px_base),
      .px_f1     (px_f1),
      .px_f3     (px_f3),
      .px_f5     (px_f5),
      .py_base   (py_base),
      .py_f3     (py_f3),
      .py_f5     (py_f5),
      .pz_neg    (pz_neg),
      .pz_pos    (pz_pos),
      .mag_ex    (mag_ex),
      .mag_ay    (mag_ay),
      .mag_cz    (mag_cz),
      .mag_ax    (mag_ax),
      .mag_cx    (mag_cx),
      .mag_cy    (mag_cy),
      .neg_ax    (neg_ax),
      .neg_cx    (neg_cx),
      .neg_cy    (neg_cy)
   );

   assign accept = start && !busy;

   // valid bits travel alongside the data; no back pressure
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STAGES-2:0], accept};
      end
   end

   // stage 3: selector = floor(cum5 * face_draw / 2^D), lowest face whose
   // cumulative weight reaches it (ties go low)
   always_comb begin
      sel3 = ((CUM_W+1)'(sp_hi2_ff) << (MUL_SPLIT - DRAW_BITS))
           + (CUM_W+1)'(sp_lo2_ff >> DRAW_BITS);
      if (sel3 <= (CUM_W+1)'(cum0)) begin
         face3_in = FACE_NEG_X;
      end else if (sel3 <= (CUM_W+1)'(cum1)) begin
         face3_in = FACE_POS_X;
      end else if (sel3 <= (CUM_W+1)'(cum2)) begin
         face3_in = FACE_NEG_Y;
      end else if (sel3 <= (CUM_W+1)'(cum3)) begin
         face3_in = FACE_POS_Y;
      end else if (sel3 <= (CUM_W+1)'(cum4)) begin
         face3_in = FACE_NEG_Z;
      end else begin
         face3_in = FACE_POS_Z;
      end
   end

   // stage 4: corner p0 and both edge vectors of the chosen face;
   // each edge lane is {negative, magnitude}
   always_comb begin
      ex_v[0] = {1'b0, mag_ex};
      ex_v[1] = '0;
      ex_v[2] = '0;
      ea_v[0] = {neg_ax, mag_ax};
      ea_v[1] = {1'b0, mag_ay};
      ea_v[2] = '0;
      ec_v[0] = {neg_cx, mag_cx};
      ec_v[1] = {neg_cy, mag_cy};
      ec_v[2] = {1'b0, mag_cz};

      p4_in[0] = px_base;
      p4_in[1] = py_base;
      p4_in[2] = pz_neg;
      e1_code  = EDGE_A;
      e2_code  = EDGE_C;
      case (face3_ff)
         FACE_NEG_X: begin
            e1_code = EDGE_A;
            e2_code = EDGE_C;
         end
         FACE_POS_X: begin
            p4_in[0] = px_f1;
            e1_code  = EDGE_C;
            e2_code  = EDGE_A;
         end
         FACE_NEG_Y: begin
            e1_code = EDGE_C;
            e2_code = EDGE_X;
         end
         FACE_POS_Y: begin
            p4_in[0] = px_f3;
            p4_in[1] = py_f3;
            e1_code  = EDGE_X;
            e2_code  = EDGE_C;
         end
         FACE_NEG_Z: begin
            e1_code = EDGE_X;
            e2_code = EDGE_A;
         end
         FACE_POS_Z: begin
            p4_in[0] = px_f5;
            p4_in[1] = py_f5;
            p4_in[2] = pz_pos;
            e1_code  = EDGE_A;
            e2_code  = EDGE_X;
         end
         default: begin
            e1_code = EDGE_A;
            e2_code = EDGE_C;
         end
      endcase

      for (int k = 0; k < NCOORD; k++) begin
         e14_in[k] = edge_pick(e1_code, ex_v[k], ea_v[k], ec_v[k]);
         e24_in[k] = edge_pick(e2_code, ex_v[k], ea_v[k], ec_v[k]);
      end
   end

   // stage 6: floor(mag * draw / 2^D) from the split products;
   // stage 7: edge sign restored (truncation toward zero) and summed
   always_comb begin
      for (int k = 0; k < NCOORD; k++) begin
         r16_wide[k] = ((EW+1)'(q1hi5_ff[k]) << (MUL_SPLIT - DRAW_BITS))
                     + (EW+1)'(q1lo5_ff[k] >> DRAW_BITS);
         r26_wide[k] = ((EW+1)'(q2hi5_ff[k]) << (MUL_SPLIT - DRAW_BITS))
                     + (EW+1)'(q2lo5_ff[k] >> DRAW_BITS);
         sr1[k]      = n16_ff[k] ? (SW'(0) - SW'(r16_ff[k])) : SW'(r16_ff[k]);
         sr2[k]      = n26_ff[k] ? (SW'(0) - SW'(r26_ff[k])) : SW'(r26_ff[k]);
         sum7_in[k]  = SW'(p6_ff[k]) + sr1[k] + sr2[k];
      end
   end

   // stage 8: clip to the signed 32-bit range
   always_comb begin
      for (int k = 0; k < NCOORD; k++) begin
         fits[k] = (&sum7_ff[k][SW-1:COORD_W-1]) || !(|sum7_ff[k][SW-1:COORD_W-1]);
         if (fits[k]) begin
            pt_in[k] = sum7_ff[k][COORD_W-1:0];
         end else if (sum7_ff[k][SW-1]) begin
            pt_in[k] = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            pt_in[k] = {1'b0, {(COORD_W-1){1'b1}}};
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      fd1_ff    <= req_face_draw;
      ud1_ff    <= req_u_draw;
      vd1_ff    <= req_v_draw;

      sp_lo2_ff <= cum5[MUL_SPLIT-1:0] * fd1_ff;
      sp_hi2_ff <= cum5[CUM_W-1:MUL_SPLIT] * fd1_ff;
      ud2_ff    <= ud1_ff;
      vd2_ff    <= vd1_ff;

      face3_ff  <= face3_in;
      ud3_ff    <= ud2_ff;
      vd3_ff    <= vd2_ff;

      face4_ff  <= face3_ff;
      ud4_ff    <= ud3_ff;
      vd4_ff    <= vd3_ff;

      face5_ff  <= face4_ff;
      face6_ff  <= face5_ff;
      face7_ff  <= face6_ff;

      for (int k = 0; k < NCOORD; k++) begin
         p4_ff[k]    <= p4_in[k];
         e14_ff[k]   <= e14_in[k];
         e24_ff[k]   <= e24_in[k];

         q1lo5_ff[k] <= e14_ff[k][MUL_SPLIT-1:0] * ud4_ff;
         q1hi5_ff[k] <= e14_ff[k][EW-1:MUL_SPLIT] * ud4_ff;
         q2lo5_ff[k] <= e24_ff[k][MUL_SPLIT-1:0] * vd4_ff;
         q2hi5_ff[k] <= e24_ff[k][EW-1:MUL_SPLIT] * vd4_ff;
         n15_ff[k]   <= e14_ff[k][EW];
         n25_ff[k]   <= e24_ff[k][EW];
         p5_ff[k]    <= p4_ff[k];

         r16_ff[k]   <= r16_wide[k][EW-1:0];
         r26_ff[k]   <= r26_wide[k][EW-1:0];
         n16_ff[k]   <= n15_ff[k];
         n26_ff[k]   <= n25_ff[k];
         p6_ff[k]    <= p5_ff[k];

         sum7_ff[k]  <= sum7_in[k];
      end

      rsp_face_ff <= face7_ff;
      rsp_x_ff    <= pt_in[0];
      rsp_y_ff    <= pt_in[1];
      rsp_z_ff    <= pt_in[2];
      rsp_sat_ff  <= !fits[0] || !fits[1] || !fits[2];
   end

   assign rsp_valid      = vld_ff[STAGES-1];
   assign rsp_face_index = rsp_face_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_point_z    = rsp_z_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

@@ sim/tb_parallelepiped_surface_point_sampler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parallelepiped_surface_point_sampler_unit
// Self-checking bench for the surface point sampler. A scoreboard class works
// out the face and the saturated Q16.16 point for every request the block
// takes. Each rsp_valid strobe is checked against the oldest expected point.
// A short directed set covers reset settings, face ties, every face and
// saturation. Random phases then change the register settings between
// drained stretches and vary the request gaps.
// ----------------------------------------------------------------------------
module tb_parallelepiped_surface_point_sampler_unit;
   import pps_pkg::*;

   localparam int CLK_HALF       = 5;
   localparam int RESET_CYCLES   = 7;
   localparam int PIPE_LATENCY   = 8;     // request edge to the edge that takes its strobe
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
   localparam int RAND_PHASES    = 8;
   localparam int PHASE_ITEMS    = 88;    // about 700 random requests overall

   localparam longint          COORD_MAX = longint'(32'sh7FFF_FFFF);
   localparam longint          COORD_MIN = longint'(32'sh8000_0000);
   localparam longint unsigned AREA_MAX  = 64'h0000_FFFF_FFFF_FFFF;

   localparam logic [FACE_W-1:0] FACE_CODES [6] = '{FACE_NEG_X, FACE_POS_X, FACE_NEG_Y,
                                                   FACE_POS_Y, FACE_NEG_Z, FACE_POS_Z};
   localparam logic [CSR_INDEX_W-1:0] REG_ORDER [8] = '{REG_HALF_X, REG_HALF_Y, REG_HALF_Z,
                                                      REG_TAN_ALPHA, REG_TAN_TCP,
                                                      REG_TAN_TSP, REG_AREA_X, REG_AREA_Y};
   // sender idle percentage per phase; phase zero runs back to back
   localparam int IDLE_PCT [4] = '{0, 48, 16, 0};

   typedef struct {
      logic [FACE_W-1:0]  face;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic               sat;
   } surface_point_type;

   typedef struct {
      logic [DRAW_BITS_DEF-1:0] face_draw;
      logic [DRAW_BITS_DEF-1:0] u_draw;
      logic [DRAW_BITS_DEF-1:0] v_draw;
   } draw_set_type;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the registers, point predictor, expected queue.
   // -------------------------------------------------------------------------
   class point_scoreboard;
      longint unsigned   half_x, half_y, half_z, area_x, area_y;
      longint            tan_a, tan_c, tan_s;
      surface_point_type pending_points [$];
      int                errors;
      int                checked;

      function new();
         half_x  = 0; half_y = 0; half_z = 0;
         tan_a   = 0; tan_c  = 0; tan_s  = 0;
         area_x  = 0; area_y = 0;
         errors  = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            REG_HALF_X:    half_x = 64'(val[31:0]);
            REG_HALF_Y:    half_y = 64'(val[31:0]);
            REG_HALF_Z:    half_z = 64'(val[31:0]);
            REG_TAN_ALPHA: tan_a  = longint'(signed'(val[31:0]));
            REG_TAN_TCP:   tan_c  = longint'(signed'(val[31:0]));
            REG_TAN_TSP:   tan_s  = longint'(signed'(val[31:0]));
            REG_AREA_X:    area_x = 64'(val);
            REG_AREA_Y:    area_y = 64'(val);
            default: ;
         endcase
      endfunction

      // floor(a * d / 2^16), exact
      function longint unsigned frac_mul(longint unsigned a, logic [DRAW_BITS_DEF-1:0] d);
         logic [127:0] prod;
         prod = {64'd0, a} * {112'd0, d};
         return prod[DRAW_BITS_DEF +: 64];
      endfunction

      // edge scaled on its magnitude, so the result truncates toward zero
      function longint scale_edge(longint e, logic [DRAW_BITS_DEF-1:0] d);
         longint unsigned mag;
         longint          r;
         mag = (e < 0) ? -e : e;
         r   = longint'(frac_mul(mag, d));
         return (e < 0) ? -r : r;
      endfunction

      function logic [COORD_W-1:0] clip_coord(longint v, inout bit sat);
         if (v > COORD_MAX) begin
            sat = 1'b1;
            return COORD_MAX[COORD_W-1:0];
         end
         if (v < COORD_MIN) begin
            sat = 1'b1;
            return COORD_MIN[COORD_W-1:0];
         end
         return v[COORD_W-1:0];
      endfunction

      function void note_request(logic [DRAW_BITS_DEF-1:0] fd, logic [DRAW_BITS_DEF-1:0] ud,
                                 logic [DRAW_BITS_DEF-1:0] vd);
         logic [127:0]      xy;
         longint unsigned   az, sel;
         longint unsigned   cum [6];
         longint            x, y, z, a, c, s;
         longint            p [3], ex [3], ea [3], ec [3], f1 [3], f2 [3];
         logic [COORD_W-1:0] coord [3];
         logic [FACE_W-1:0] face;
         bit                sat;
         surface_point_type pt;

         // z face area is 4*Dx*Dy, clipped to 48 bits
         xy = {64'd0, half_x} * {64'd0, half_y};
         xy = xy >> (COORD_FRAC_BITS_DEF - 2);
         az = (xy > AREA_MAX) ? AREA_MAX : xy[63:0];
         cum[0] = area_x;
         cum[1] = cum[0] + area_x;
         cum[2] = cum[1] + area_y;
         cum[3] = cum[2] + area_y;
         cum[4] = cum[3] + az;
         cum[5] = cum[4] + az;
         sel    = frac_mul(cum[5], fd);
         // lowest face whose running weight covers the selector wins ties
         face = FACE_POS_Z;
         for (int k = 4; k >= 0; k--)
            if (sel <= cum[k])
               face = FACE_CODES[k];

         x = half_x;
         y = half_y;
         z = half_z;
         a = (y * tan_a) >>> COORD_FRAC_BITS_DEF;
         c = (z * tan_c) >>> COORD_FRAC_BITS_DEF;
         s = (z * tan_s) >>> COORD_FRAC_BITS_DEF;

         p  = '{-c - a - x, -s - y, -z};
         ex = '{2 * x, 0, 0};
         ea = '{2 * a, 2 * y, 0};
         ec = '{2 * c, 2 * s, 2 * z};
         f1 = ea;
         f2 = ec;
         case (face)
            FACE_POS_X: begin
               p[0] = -c - a + x;
               f1 = ec; f2 = ea;
            end
            FACE_NEG_Y: begin
               f1 = ec; f2 = ex;
            end
            FACE_POS_Y: begin
               p[0] = -c + a - x;
               p[1] = -s + y;
               f1 = ex; f2 = ec;
            end
            FACE_NEG_Z: begin
               f1 = ex; f2 = ea;
            end
            FACE_POS_Z: begin
               p[0] = c - a - x;
               p[1] = s - y;
               p[2] = z;
               f1 = ea; f2 = ex;
            end
            default: ;
         endcase

         sat = 1'b0;
         for (int k = 0; k < 3; k++)
            coord[k] = clip_coord(p[k] + scale_edge(f1[k], ud) + scale_edge(f2[k], vd), sat);
         pt.face = face;
         pt.x    = coord[0];
         pt.y    = coord[1];
         pt.z    = coord[2];
         pt.sat  = sat;
         pending_points.push_back(pt);
      endfunction

      function void compare_field(string name, logic [COORD_W-1:0] want,
                                  logic [COORD_W-1:0] got);
         if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(logic [FACE_W-1:0] face, logic [COORD_W-1:0] x,
                                 logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, logic sat);
         surface_point_type want;
         if (pending_points.size() == 0) begin
            $display("%0t ns: result with no request pending, face %0d point %h %h %h",
                     $time, face, x, y, z);
            errors++;
            return;
         end
         want = pending_points.pop_front();
         checked++;
         compare_field("face_index", COORD_W'(want.face), COORD_W'(face));
         compare_field("point_x", want.x, x);
         compare_field("point_y", want.y, y);
         compare_field("point_z", want.z, z);
         compare_field("saturated", COORD_W'(want.sat), COORD_W'(sat));
      endfunction

      function int pending();
         return pending_points.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // DUT signals
   // -------------------------------------------------------------------------
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [DRAW_BITS_DEF-1:0] req_face_draw = '0;
   logic [DRAW_BITS_DEF-1:0] req_u_draw    = '0;
   logic [DRAW_BITS_DEF-1:0] req_v_draw    = '0;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     rsp_valid;
   logic [FACE_W-1:0]        rsp_face_index;
   logic signed [COORD_W-1:0] rsp_point_x;
   logic signed [COORD_W-1:0] rsp_point_y;
   logic signed [COORD_W-1:0] rsp_point_z;
   logic                     rsp_saturated;

   point_scoreboard board = new();

   draw_set_type      draw_queue [$];     // requests waiting to be sent
   logic [CSR_DATA_W-1:0] settings [8];   // next register set to load
   int                requests_sent = 0;
   int                settings_loaded = 0;
   int                stall_cycles = 0;

   parallelepiped_surface_point_sampler_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_face_draw  (req_face_draw),
      .req_u_draw     (req_u_draw),
      .req_v_draw     (req_v_draw),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .rsp_valid      (rsp_valid),
      .rsp_face_index (rsp_face_index),
      .rsp_point_x    (rsp_point_x),
      .rsp_point_y    (rsp_point_y),
      .rsp_point_z    (rsp_point_z),
      .rsp_saturated  (rsp_saturated)
   );

   always #CLK_HALF clock = ~clock;

   // result monitor: outputs read at the edge are those of the cycle just ended
   always @(posedge clock) begin
      if (!reset && rsp_valid)
         board.check_result(rsp_face_index, rsp_point_x, rsp_point_y, rsp_point_z,
                            rsp_saturated);
   end

   // watchdog: any request, result or register write counts as progress
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("parallelepiped_surface_point_sampler_unit regression: fail");
         $finish;
      end
   end

   function automatic void add_draws(logic [DRAW_BITS_DEF-1:0] fd,
                                     logic [DRAW_BITS_DEF-1:0] ud,
                                     logic [DRAW_BITS_DEF-1:0] vd);
      draw_set_type d;
      d.face_draw = fd;
      d.u_draw    = ud;
      d.v_draw    = vd;
      draw_queue.push_back(d);
   endfunction

   // a draw value biased toward the ends and the midpoint of its range now and then
   function automatic logic [DRAW_BITS_DEF-1:0] pick_draw();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return 16'h8000;
         default: return 16'($urandom_range(16'hFFFF));
      endcase
   endfunction

   // one register value; mode 0 plausible geometry, 1 any bits, 2 extremes or any bits
   function automatic logic [CSR_DATA_W-1:0] pick_reg(logic [CSR_INDEX_W-1:0] idx, int mode);
      logic [CSR_DATA_W-1:0] any_bits;
      bit is_area, is_tan;
      is_area  = (idx == REG_AREA_X) || (idx == REG_AREA_Y);
      is_tan   = (idx == REG_TAN_ALPHA) || (idx == REG_TAN_TCP) || (idx == REG_TAN_TSP);
      any_bits = is_area ? {16'($urandom), 32'($urandom)} : {16'd0, 32'($urandom)};
      case (mode)
         0: begin
            if (is_area)
               return 48'($urandom_range(32'h0100_0000));
            if (is_tan)
               return {16'd0, 32'($urandom_range(32'h0004_0000)) - 32'h0002_0000};
            return 48'($urandom_range(32'h0010_0000));
         end
         1: return any_bits;
         default: begin
            case ($urandom_range(3))
               0: return '0;
               1: return is_area ? 48'hFFFF_FFFF_FFFF :
                         (is_tan ? 48'h7FFF_FFFF : 48'hFFFF_FFFF);
               2: return is_tan ? 48'h8000_0000 : (is_area ? 48'h1 : 48'h1_0000);
               default: return any_bits;
            endcase
         end
      endcase
   endfunction

   // write all eight registers back to back, valid held across the burst
   task automatic load_settings();
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= REG_ORDER[i];
         csr_wdata <= settings[i];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
         board.write_reg(REG_ORDER[i], settings[i]);
      end
      csr_valid <= 1'b0;
      settings_loaded++;
   endtask

   // send every queued request; start is only touched once per edge
   task automatic send_draws(input int idle_pct);
      draw_set_type d;
      while (draw_queue.size() > 0) begin
         if ($urandom_range(99) >= idle_pct) begin
            d = draw_queue[0];
            start         <= 1'b1;
            req_face_draw <= d.face_draw;
            req_u_draw    <= d.u_draw;
            req_v_draw    <= d.v_draw;
         end else begin
            start <= 1'b0;
         end
         @(posedge clock);
         while (start && busy)
            @(posedge clock);
         if (start) begin
            board.note_request(req_face_draw, req_u_draw, req_v_draw);
            void'(draw_queue.pop_front());
            requests_sent++;
         end
      end
      start <= 1'b0;
   endtask

   // block is idle once every expected point is back and the pipe has emptied
   task automatic drain();
      while (board.pending() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: every area zero, so face 0 and the origin
      add_draws(16'h0000, 16'h0000, 16'h0000);
      add_draws(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_draws(0);
      drain();

      // no z area and equal x/y areas: selector lands exactly on face weights
      settings = '{48'h0000_0000, 48'h0001_8000, 48'h0002_0000, 48'hFFFF_0000,
                   48'h0000_8000, 48'hFFFF_8000, 48'h0000_8000, 48'h0000_8000};
      load_settings();
      add_draws(16'h0000, 16'h0000, 16'hFFFF);
      add_draws(16'h4000, 16'hFFFF, 16'h0000);  // tie with face 0 weight
      add_draws(16'h4001, 16'h8000, 16'h8000);
      add_draws(16'h8000, 16'h0001, 16'hFFFF);  // tie with face 1 weight
      add_draws(16'hC000, 16'hFFFF, 16'hFFFF);  // tie with face 2 weight
      add_draws(16'hC001, 16'h1234, 16'h4321);
      add_draws(16'hFFFF, 16'h0000, 16'h0000);
      send_draws(0);
      drain();

      // unit cube-ish with small shears: six equal areas, every face drawn at least once
      settings = '{48'h0001_0000, 48'h0001_0000, 48'h0001_0000, 48'h0000_4000,
                   48'hFFFF_C000, 48'h0000_2000, 48'h0004_0000, 48'h0004_0000};
      load_settings();
      add_draws(16'h0000, 16'hFFFF, 16'h0000);
      add_draws(16'h3000, 16'h0000, 16'hFFFF);
      add_draws(16'h5800, 16'h8000, 16'h8000);
      add_draws(16'h8000, 16'hFFFF, 16'hFFFF);
      add_draws(16'h9000, 16'h0001, 16'h7FFF);
      add_draws(16'hB000, 16'hFFFF, 16'h0001);
      add_draws(16'hE000, 16'hAAAA, 16'h5555);
      add_draws(16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_draws(0);
      drain();

      // largest sizes and shears: z area clips and coordinates saturate
      settings = '{48'hFFFF_FFFF, 48'hFFFF_FFFF, 48'hFFFF_FFFF, 48'h7FFF_FFFF,
                   48'h8000_0000, 48'h7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF};
      load_settings();
      add_draws(16'h0000, 16'hFFFF, 16'hFFFF);
      add_draws(16'h8000, 16'hFFFF, 16'h0000);
      add_draws(16'hFFFF, 16'hFFFF, 16'hFFFF);
      add_draws(16'h5555, 16'h0000, 16'hFFFF);
      send_draws(0);
      drain();

      // random phases: new register set, then a stream with its own gap rate
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         for (int i = 0; i < 8; i++)
            settings[i] = pick_reg(REG_ORDER[i], ph % 3);
         load_settings();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(4) == 0)
               add_draws(pick_draw(), pick_draw(), pick_draw());
            else
               add_draws(16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                         16'($urandom_range(16'hFFFF)));
         end
         send_draws(IDLE_PCT[ph % 4]);
         drain();
      end

      $display("Covered %0d requests under %0d register sets; %0d points checked.",
               requests_sent, settings_loaded, board.checked);
      $display("Directed ties, all six faces and saturation ran ahead of the random mix.");
      if (board.errors == 0)
         $display("parallelepiped_surface_point_sampler_unit regression: pass");
      else
         $display("parallelepiped_surface_point_sampler_unit regression: fail");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/pps_pkg.sv
hdl/pps_cfg.sv
hdl/parallelepiped_surface_point_sampler_unit.sv
sim/tb_parallelepiped_surface_point_sampler_unit.sv
